### hdl/tcf_pkg.sv
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared codes, types and helpers for the Telnet command filter.
// ----------------------------------------------------------------------------
package tcf_pkg;

	// Telnet command bytes
	localparam logic [7:0] TN_IAC  = 8'd255;
	localparam logic [7:0] TN_DONT = 8'd254;
	localparam logic [7:0] TN_DO   = 8'd253;
	localparam logic [7:0] TN_WONT = 8'd252;
	localparam logic [7:0] TN_WILL = 8'd251;
	localparam logic [7:0] TN_SB   = 8'd250;
	localparam logic [7:0] TN_SE   = 8'd240;

	// Result kinds
	localparam logic KIND_DATA  = 1'b0;
	localparam logic KIND_REPLY = 1'b1;

	typedef enum logic [2:0] {
		ST_DATA   = 3'd0,
		ST_CMD    = 3'd1,
		ST_OPTION = 3'd2,
		ST_SUB    = 3'd3,
		ST_SUBCMD = 3'd4
	} tcf_state_t;

	typedef enum logic [1:0] {
		VERB_DO   = 2'd0,
		VERB_DONT = 2'd1,
		VERB_WILL = 2'd2,
		VERB_WONT = 2'd3
	} tcf_verb_t;

	// What one received byte produces, handed from parser to emitter
	typedef struct packed {
		logic       has;    // at least one result
		logic       multi;  // three-beat reply
		logic       kind;
		logic [7:0] data;   // data byte or option byte
		tcf_verb_t  verb;   // received verb for a reply
	} tcf_res_t;

	// Mirror a received verb: DO and WILL swap, DONT and WONT swap
	function automatic logic [7:0] reply_code(tcf_verb_t verb);
		logic [7:0] code;
		case (verb)
			VERB_DO:   code = TN_WILL;
			VERB_DONT: code = TN_WONT;
			VERB_WILL: code = TN_DO;
			VERB_WONT: code = TN_DONT;
			default:   code = TN_WILL;
		endcase
		return code;
	endfunction

endpackage

### hdl/telnet_command_filter.sv
// ----------------------------------------------------------------------------
// telnet_command_filter
// Telnet receive filter: passes data, drops commands, mirrors option requests.
// ----------------------------------------------------------------------------
// A byte is registered in the input register on accept; its results are loaded
// into the result register when the emitter is free. Throughput: one byte per
// cycle unless stalled; an option byte holds the result register for three
// output beats, during which one further byte can wait in the input register.
// Reset clears the parser to the data state and empties both registers.
module telnet_command_filter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       out_kind,
	output logic [7:0] out_byte,
	output logic       out_last
);

	logic              rx_valid_s1;
	logic [7:0]        rx_byte_s1;
	logic              adv;
	logic              free;
	tcf_pkg::tcf_res_t res;

	// advance a byte with no result at once; otherwise wait for the emitter
	assign adv      = rx_valid_s1 && (!res.has || free);
	assign in_stall = rx_valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			rx_valid_s1 <= 1'b1;
		end else if (adv) begin
			rx_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	tcf_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.rx_byte (rx_byte_s1),
		.res     (res)
	);

	tcf_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && res.has),
		.res       (res),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_kind  (out_kind),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

	// data results are always single beats
	a_data_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == tcf_pkg::KIND_DATA) |-> out_last)
		else $error("data result spans more than one beat");

	// a reply that is not finished continues on the next cycle
	a_reply_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_last |=> out_valid && out_kind)
		else $error("reply sequence broken");

	// a reply starts with IAC
	a_reply_starts_iac: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_last |=>
		!out_valid || out_last || (out_byte == tcf_pkg::TN_IAC))
		else $error("reply does not start with IAC");

	// a byte waiting in the input register is never lost
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		rx_valid_s1 && !adv |=> rx_valid_s1 && $stable(rx_byte_s1))
		else $error("waiting input byte lost");

endmodule

### hdl/tcf_parser.sv
// ----------------------------------------------------------------------------
// tcf_parser
// Command parser state machine: classifies each byte and says what it emits.
// ----------------------------------------------------------------------------
module tcf_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	output tcf_pkg::tcf_res_t res
);

	tcf_pkg::tcf_state_t state_q, state_d;
	tcf_pkg::tcf_verb_t  verb_q, verb_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcf_pkg::ST_DATA;
			verb_q  <= tcf_pkg::VERB_DO;
		end else if (step) begin
			state_q <= state_d;
			verb_q  <= verb_d;
		end
	end

	always_comb begin
		state_d   = tcf_pkg::ST_DATA;
		verb_d    = verb_q;
		res.has   = 1'b0;
		res.multi = 1'b0;
		res.kind  = tcf_pkg::KIND_DATA;
		res.data  = rx_byte;
		res.verb  = verb_q;
		case (state_q)
			tcf_pkg::ST_CMD: begin
				if (rx_byte == tcf_pkg::TN_IAC) begin
					// escaped IAC is data 255
					res.has = 1'b1;
				end else if (rx_byte == tcf_pkg::TN_SB) begin
					state_d = tcf_pkg::ST_SUB;
				end else if (rx_byte inside {tcf_pkg::TN_DO, tcf_pkg::TN_DONT,
						tcf_pkg::TN_WILL, tcf_pkg::TN_WONT}) begin
					state_d = tcf_pkg::ST_OPTION;
					case (rx_byte)
						tcf_pkg::TN_DO:   verb_d = tcf_pkg::VERB_DO;
						tcf_pkg::TN_DONT: verb_d = tcf_pkg::VERB_DONT;
						tcf_pkg::TN_WILL: verb_d = tcf_pkg::VERB_WILL;
						default:          verb_d = tcf_pkg::VERB_WONT;
					endcase
				end
			end
			tcf_pkg::ST_OPTION: begin
				res.has   = 1'b1;
				res.multi = 1'b1;
				res.kind  = tcf_pkg::KIND_REPLY;
			end
			tcf_pkg::ST_SUB: begin
				state_d = (rx_byte == tcf_pkg::TN_IAC) ? tcf_pkg::ST_SUBCMD : tcf_pkg::ST_SUB;
			end
			tcf_pkg::ST_SUBCMD: begin
				state_d = (rx_byte == tcf_pkg::TN_SE) ? tcf_pkg::ST_DATA : tcf_pkg::ST_SUB;
			end
			default: begin
				if (rx_byte == tcf_pkg::TN_IAC) begin
					state_d = tcf_pkg::ST_CMD;
				end else begin
					res.has = 1'b1;
				end
			end
		endcase
	end

endmodule

### hdl/tcf_emitter.sv
// ----------------------------------------------------------------------------
// tcf_emitter
// Result register: holds one byte's results and sends them beat by beat.
// ----------------------------------------------------------------------------
module tcf_emitter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  tcf_pkg::tcf_res_t res,
	output logic              free,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              out_kind,
	output logic [7:0]        out_byte,
	output logic              out_last
);

	logic               valid_q;
	logic [1:0]         idx_q;
	logic               multi_q;
	logic               kind_q;
	logic [7:0]         byte_q;
	tcf_pkg::tcf_verb_t verb_q;
	logic               beat;

	assign beat = valid_q && !out_stall;
	assign free = !valid_q || (beat && out_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (beat) begin
			if (out_last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			multi_q <= res.multi;
			kind_q  <= res.kind;
			byte_q  <= res.data;
			verb_q  <= res.verb;
		end
	end

	assign out_valid = valid_q;
	assign out_kind  = kind_q;

	always_comb begin
		case (idx_q)
			2'd0: begin
				out_byte = multi_q ? tcf_pkg::TN_IAC : byte_q;
				out_last = !multi_q;
			end
			2'd1: begin
				out_byte = tcf_pkg::reply_code(verb_q);
				out_last = 1'b0;
			end
			default: begin
				out_byte = byte_q;
				out_last = 1'b1;
			end
		endcase
	end

endmodule

### sim/telnet_command_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_command_filter_test
// Drives received Telnet bytes into the command filter under random idling
// and output stalls, predicts the data and reply beats each byte produces,
// and checks every output beat in order against that prediction.
// ----------------------------------------------------------------------------
module telnet_command_filter_test;

	localparam int CLK_PERIOD   = 4;
	localparam int RESET_CYCLES = 7;
	localparam int QUIET_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 8;
	localparam int HOLD_CYCLES  = 80;
	localparam logic [7:0] TN_NOP = 8'd241;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic       last;
	} tcf_beat_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte   = 8'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       out_kind;
	logic [7:0] out_byte;
	logic       out_last;

	tcf_beat_t           pending_beats[$];
	tcf_pkg::tcf_state_t parse_state = tcf_pkg::ST_DATA;
	tcf_pkg::tcf_verb_t  held_verb   = tcf_pkg::VERB_DO;
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	int         hold_requests = 0;
	int         error_count   = 0;
	int         quiet_cycles  = 0;
	int         sent_count    = 0;

	telnet_command_filter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_kind  (out_kind),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Parse one received byte and queue the beats it should produce
	function automatic void parse_rx_byte(input logic [7:0] b);
		logic [7:0] mirrored;
		case (parse_state)
			tcf_pkg::ST_CMD: begin
				parse_state = tcf_pkg::ST_DATA;
				if (b == tcf_pkg::TN_IAC) begin
					pending_beats.push_back('{tcf_pkg::KIND_DATA, tcf_pkg::TN_IAC, 1'b1});
				end else if (b == tcf_pkg::TN_SB) begin
					parse_state = tcf_pkg::ST_SUB;
				end else if (b inside {tcf_pkg::TN_DO, tcf_pkg::TN_DONT,
						tcf_pkg::TN_WILL, tcf_pkg::TN_WONT}) begin
					case (b)
						tcf_pkg::TN_DO:   held_verb = tcf_pkg::VERB_DO;
						tcf_pkg::TN_DONT: held_verb = tcf_pkg::VERB_DONT;
						tcf_pkg::TN_WILL: held_verb = tcf_pkg::VERB_WILL;
						default:          held_verb = tcf_pkg::VERB_WONT;
					endcase
					parse_state = tcf_pkg::ST_OPTION;
				end
			end
			tcf_pkg::ST_OPTION: begin
				// answer by mirroring: a request is answered with its opposite side
				case (held_verb)
					tcf_pkg::VERB_DO:   mirrored = tcf_pkg::TN_WILL;
					tcf_pkg::VERB_DONT: mirrored = tcf_pkg::TN_WONT;
					tcf_pkg::VERB_WILL: mirrored = tcf_pkg::TN_DO;
					default:            mirrored = tcf_pkg::TN_DONT;
				endcase
				pending_beats.push_back('{tcf_pkg::KIND_REPLY, tcf_pkg::TN_IAC, 1'b0});
				pending_beats.push_back('{tcf_pkg::KIND_REPLY, mirrored, 1'b0});
				pending_beats.push_back('{tcf_pkg::KIND_REPLY, b, 1'b1});
				parse_state = tcf_pkg::ST_DATA;
			end
			tcf_pkg::ST_SUB: begin
				if (b == tcf_pkg::TN_IAC)
					parse_state = tcf_pkg::ST_SUBCMD;
			end
			tcf_pkg::ST_SUBCMD: begin
				parse_state = (b == tcf_pkg::TN_SE) ? tcf_pkg::ST_DATA : tcf_pkg::ST_SUB;
			end
			default: begin
				if (b == tcf_pkg::TN_IAC) begin
					parse_state = tcf_pkg::ST_CMD;
				end else begin
					pending_beats.push_back('{tcf_pkg::KIND_DATA, b, 1'b1});
					parse_state = tcf_pkg::ST_DATA;
				end
			end
		endcase
	endfunction

	// Offer one byte, idling first at random, and hold it until accepted
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do
			@(posedge clk);
		while (in_stall);
		parse_rx_byte(b);
		sent_count++;
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_iac_pair(input logic [7:0] cmd);
		send_byte(tcf_pkg::TN_IAC);
		send_byte(cmd);
	endtask

	// Receiver: random stalls, plus a long hold whenever one is requested
	always @(posedge clk) begin
		static int hold_seen = 0;
		static int hold_left = 0;
		if (hold_requests != hold_seen) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Check each output beat against the oldest expectation
	always @(posedge clk) begin
		tcf_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected beat kind=%0d byte=%0d last=%0d",
					$time, out_kind, out_byte, out_last);
				error_count++;
			end else begin
				want = pending_beats.pop_front();
				if (out_kind !== want.kind) begin
					$display("%0t: out_kind expected %0d actual %0d", $time, want.kind, out_kind);
					error_count++;
				end
				if (out_byte !== want.data) begin
					$display("%0t: out_byte expected %0d actual %0d", $time, want.data, out_byte);
					error_count++;
				end
				if (out_last !== want.last) begin
					$display("%0t: out_last expected %0d actual %0d", $time, want.last, out_last);
					error_count++;
				end
			end
		end
	end

	// Watchdog: end the run if no beat moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
				$display("telnet_command_filter_test: done, errors");
				$finish;
			end
		end
	end

	task automatic test_plain_data();
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'h7f);
		send_iac_pair(tcf_pkg::TN_IAC);
	endtask

	task automatic test_option_replies();
		send_iac_pair(tcf_pkg::TN_DO);
		send_byte(8'h00);
		send_iac_pair(tcf_pkg::TN_DONT);
		send_byte(tcf_pkg::TN_IAC);
		send_iac_pair(tcf_pkg::TN_WILL);
		send_byte(8'h01);
		send_iac_pair(tcf_pkg::TN_WONT);
		send_byte(8'h18);
	endtask

	task automatic test_subnegotiation();
		send_iac_pair(tcf_pkg::TN_SB);
		send_byte(8'h18);
		send_iac_pair(8'h00);
		send_iac_pair(tcf_pkg::TN_SE);
	endtask

	task automatic test_dropped_commands();
		send_iac_pair(TN_NOP);
		send_iac_pair(tcf_pkg::TN_SE);
		send_iac_pair(8'h10);
	endtask

	// Mostly well-formed sequences with random content, some noise bytes
	task automatic test_random_traffic(input int n_items, input int snd_pct, input int rcv_pct);
		int start;
		int pick;
		int body;
		logic [7:0] b;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		start = sent_count;
		while (sent_count - start < n_items) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				send_byte(8'($urandom_range(254)));
			end else if (pick < 50) begin
				send_iac_pair(tcf_pkg::TN_IAC);
			end else if (pick < 75) begin
				case ($urandom_range(3))
					0:       send_iac_pair(tcf_pkg::TN_DO);
					1:       send_iac_pair(tcf_pkg::TN_DONT);
					2:       send_iac_pair(tcf_pkg::TN_WILL);
					default: send_iac_pair(tcf_pkg::TN_WONT);
				endcase
				send_byte(8'($urandom_range(255)));
			end else if (pick < 85) begin
				send_iac_pair(tcf_pkg::TN_SB);
				body = $urandom_range(6);
				repeat (body) begin
					if ($urandom_range(3) == 0) begin
						// escaped command inside the subnegotiation: anything but SE
						do
							b = 8'($urandom_range(255));
						while (b == tcf_pkg::TN_SE);
						send_iac_pair(b);
					end else begin
						send_byte(8'($urandom_range(254)));
					end
				end
				send_iac_pair(tcf_pkg::TN_SE);
			end else if (pick < 93) begin
				send_iac_pair(8'($urandom_range(249)));
			end else begin
				send_byte(8'($urandom_range(255)));
			end
		end
	endtask

	// Hold the output long enough for the block to fill and stall its input
	task automatic test_output_hold();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests <= hold_requests + 1;
		repeat (12)
			send_byte(8'($urandom_range(254)));
		send_iac_pair(tcf_pkg::TN_WILL);
		send_byte(8'h03);
		wait_results_drained();
	endtask

	task automatic test_sender_pause();
		send_idle_pct = 10;
		recv_idle_pct = 30;
		repeat (4) begin
			send_iac_pair(tcf_pkg::TN_DO);
			send_byte(8'($urandom_range(255)));
			send_byte(8'($urandom_range(254)));
			wait_results_drained();
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 37;
		recv_idle_pct = 59;
		test_plain_data();
		test_option_replies();
		test_subnegotiation();
		test_dropped_commands();

		test_random_traffic(140, 37, 59);
		test_random_traffic(140, 59, 37);
		test_random_traffic(140, 0, 0);
		test_output_hold();
		test_sender_pause();

		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("telnet_command_filter_test: done, clean");
		else
			$display("telnet_command_filter_test: done, errors");
		$finish;
	end

endmodule

### telnet_command_filter.f
hdl/tcf_pkg.sv
hdl/tcf_parser.sv
hdl/tcf_emitter.sv
hdl/telnet_command_filter.sv
sim/telnet_command_filter_test.sv
